// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked assertions that are held off while reset is applied.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge of clk_i.
`define PFS_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge of clk_i.
`define PFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/pfs_pkg.sv -----
// ----------------------------------------------------------------------------
// pfs_pkg
// Item types and constants shared by the face skewness modules.
// ----------------------------------------------------------------------------
package pfs_pkg;

  localparam int FIELD_BITS     = 24;
  localparam int SCORE_W        = 16;
  localparam int TOTAL_W        = 20;
  localparam int ONE_Q15        = 32768;
  localparam int TOTAL_MAX      = 1048575;
  localparam int MAX_FACES_DEF  = 16;
  localparam int COORD_BITS_DEF = 24;

  typedef struct packed {
    logic signed [FIELD_BITS-1:0] coord_x;
    logic signed [FIELD_BITS-1:0] coord_y;
    logic signed [FIELD_BITS-1:0] coord_z;
    logic                         face_end;
    logic                         group_end;
  } in_item_t;

  typedef struct packed {
    logic [SCORE_W-1:0] face_score;
    logic [TOTAL_W-1:0] group_total;
    logic               group_done;
  } out_item_t;

  // Control that travels with each corner job through the queue.
  typedef struct packed {
    logic corner;  // job carries a corner to evaluate
    logic last;    // face closes after this job
    logic grp;     // closing face also closes the group
  } job_ctl_t;

endpackage

// ----- hw/rtl/polygon_face_skewness_core.sv -----
// ----------------------------------------------------------------------------
// polygon_face_skewness_core
// Streaming face skewness: largest corner cosine per polygon face, Q1.15.
// ----------------------------------------------------------------------------
// Vertices come in one item at a time; face_end marks the last vertex of a
// face and group_end on that item closes the group. Every face end gives one
// result item with the face score and the saturating group total. The front
// takes a vertex while idle. From the third vertex of a face on, it then
// issues a corner job into a two-entry queue and holds the input until the
// job is in. A closing item holds it while its three jobs go in, or its one
// job for a face of one or two vertices. Whenever the queue is full, the
// input is held until the back frees a slot. The back evaluates each corner
// on one shared multiplier: it takes the job, forms the edge vectors, sums
// the norms and dot product, checks them, builds the wide products, runs the
// bit-by-bit cosine search and folds the cosine into the face maximum. A
// face of n vertices has n corners. A corner with a zero-length edge or a
// non-positive cosine skips the wide products and the search. A face of
// fewer than three vertices goes straight from taking its job to giving its
// result.
module polygon_face_skewness_core #(
  parameter int MaxFaces  = pfs_pkg::MAX_FACES_DEF,
  parameter int CoordBits = pfs_pkg::COORD_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  pfs_pkg::in_item_t    in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output pfs_pkg::out_item_t   out_item_o
);
  import pfs_pkg::*;

  localparam int JW = 9 * CoordBits;
  localparam int QW = JW + $bits(job_ctl_t);

  logic          job_valid, job_full, q_valid, q_pop;
  logic [JW-1:0] job_data;
  job_ctl_t      job_ctl, q_ctl;
  logic [QW-1:0] q_data;

  // Front: vertex tracking and job issue.
  pfs_front #(.CoordBits(CoordBits)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .job_valid_o (job_valid),
    .job_full_i  (job_full),
    .job_data_o  (job_data),
    .job_ctl_o   (job_ctl)
  );

  // Decouple the two halves.
  pfs_queue #(.Width(QW)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_valid),
    .data_i  ({job_ctl, job_data}),
    .full_o  (job_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_data)
  );

  assign q_ctl = q_data[QW-1:JW];

  // Back: corner arithmetic, face maximum, group total.
  pfs_back #(.MaxFaces(MaxFaces), .CoordBits(CoordBits)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_pop_o   (q_pop),
    .job_data_i  (q_data[JW-1:0]),
    .job_ctl_i   (q_ctl),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ----- hw/rtl/pfs_front.sv -----
// ----------------------------------------------------------------------------
// pfs_front
// Accept vertices, track the open face and issue corner jobs to the queue.
// ----------------------------------------------------------------------------
module pfs_front #(
  parameter int CoordBits = pfs_pkg::COORD_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  pfs_pkg::in_item_t        in_item_i,
  output logic                     job_valid_o,
  input  logic                     job_full_i,
  output logic [9*CoordBits-1:0]   job_data_o,
  output pfs_pkg::job_ctl_t        job_ctl_o
);
  import pfs_pkg::*;

  localparam int VW = 3 * CoordBits;

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_JOB0 = 4'b0010,
    F_JOB1 = 4'b0100,
    F_JOB2 = 4'b1000
  } front_state_e;

  front_state_e state_q, state_d;
  logic [VW-1:0] first_q, second_q, older_q, newer_q, prev_q;
  logic [1:0]    seen_q, seen_d;
  logic          main_q, close_q, grp_q;
  logic [VW-1:0] vtx;
  logic          accept, push;

  assign vtx = {CoordBits'(in_item_i.coord_z), CoordBits'(in_item_i.coord_y),
                CoordBits'(in_item_i.coord_x)};
  assign in_stall_o = (state_q != F_IDLE);
  assign accept     = in_valid_i && (state_q == F_IDLE);
  assign job_valid_o = (state_q != F_IDLE);
  assign push        = job_valid_o && !job_full_i;

  always_comb begin
    seen_d = seen_q;
    case (seen_q)
      2'd0:    seen_d = 2'd1;
      2'd1:    seen_d = 2'd2;
      default: seen_d = 2'd3;
    endcase
    if (in_item_i.face_end) begin
      seen_d = 2'd0;
    end
  end

  // Job contents and sequencing.
  always_comb begin
    state_d    = state_q;
    job_data_o = {prev_q, older_q, newer_q};
    job_ctl_o  = '{corner: main_q, last: close_q && !main_q, grp: grp_q};
    case (state_q)
      F_IDLE: begin
        if (accept && (seen_q >= 2'd2 || in_item_i.face_end)) begin
          state_d = F_JOB0;
        end
      end
      F_JOB0: begin
        if (push) begin
          state_d = (main_q && close_q) ? F_JOB1 : F_IDLE;
        end
      end
      F_JOB1: begin
        job_data_o = {older_q, newer_q, first_q};
        job_ctl_o  = '{corner: 1'b1, last: 1'b0, grp: grp_q};
        if (push) begin
          state_d = F_JOB2;
        end
      end
      F_JOB2: begin
        job_data_o = {newer_q, first_q, second_q};
        job_ctl_o  = '{corner: 1'b1, last: 1'b1, grp: grp_q};
        if (push) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      seen_q  <= 2'd0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        seen_q <= seen_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      main_q  <= (seen_q >= 2'd2);
      close_q <= in_item_i.face_end;
      grp_q   <= in_item_i.group_end;
      case (seen_q)
        2'd0: begin
          first_q <= vtx;
          newer_q <= vtx;
        end
        2'd1: begin
          second_q <= vtx;
          older_q  <= newer_q;
          newer_q  <= vtx;
        end
        default: begin
          prev_q  <= older_q;
          older_q <= newer_q;
          newer_q <= vtx;
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/pfs_queue.sv -----
// ----------------------------------------------------------------------------
// pfs_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
module pfs_queue #(
  parameter int Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] data_o
);
  logic [Width-1:0] slot_q [2];
  logic             wr_q, rd_q;
  logic [1:0]       fill_q;
  logic             do_push, do_pop;

  assign full_o  = (fill_q == 2'd2);
  assign valid_o = (fill_q != 2'd0);
  assign data_o  = slot_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      if (do_push) begin
        wr_q <= !wr_q;
      end
      if (do_pop) begin
        rd_q <= !rd_q;
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + 2'd1;
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= data_i;
    end
  end

endmodule

// ----- hw/rtl/pfs_back.sv -----
// ----------------------------------------------------------------------------
// pfs_back
// Evaluate corner cosines on one shared multiplier, keep the face maximum,
// and emit face score and group total.
// ----------------------------------------------------------------------------
module pfs_back #(
  parameter int MaxFaces  = pfs_pkg::MAX_FACES_DEF,
  parameter int CoordBits = pfs_pkg::COORD_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    job_valid_i,
  output logic                    job_pop_o,
  input  logic [9*CoordBits-1:0]  job_data_i,
  input  pfs_pkg::job_ctl_t       job_ctl_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output pfs_pkg::out_item_t      out_item_o
);
  import pfs_pkg::*;

  localparam int CW = CoordBits;
  localparam int VW = 3 * CW;
  localparam int DW = CW + 1;      // edge component
  localparam int L  = CW + 2;      // limb of a norm
  localparam int MW = L + 1;       // multiplier operand
  localparam int NW = 2 * L;       // norms and dot product
  localparam int PW = 2 * NW;      // norm product, dot squared
  localparam int SW = PW + 33;     // search accumulators
  localparam int CAP_FULL = MaxFaces * ONE_Q15;
  localparam logic [TOTAL_W-1:0] CAP =
    TOTAL_W'((CAP_FULL > TOTAL_MAX) ? TOTAL_MAX : CAP_FULL);

  typedef enum logic [10:0] {
    B_IDLE   = 11'b00000000001,
    B_DIFF   = 11'b00000000010,
    B_MUL    = 11'b00000000100,
    B_ACC    = 11'b00000001000,
    B_CHECK  = 11'b00000010000,
    B_WMUL   = 11'b00000100000,
    B_WACC   = 11'b00001000000,
    B_SRCH_A = 11'b00010000000,
    B_SRCH_B = 11'b00100000000,
    B_FIN    = 11'b01000000000,
    B_EMIT   = 11'b10000000000
  } back_state_e;

  back_state_e state_q;
  logic [9*CW-1:0]        ent_q;
  job_ctl_t               ctl_q;
  logic signed [DW-1:0]   a_q [3];
  logic signed [DW-1:0]   b_q [3];
  logic [3:0]             cnt_q;
  logic signed [2*MW-1:0] prod_q;
  logic [NW-1:0]          na_q, nb_q, mag_q;
  logic signed [NW-1:0]   dot_q;
  logic [PW-1:0]          pn_q, dd_q;
  logic [SW-1:0]          s_q, t_q, tmp_q;
  logic [SCORE_W-1:0]     k_q, best_q;
  logic [3:0]             bit_q;
  logic [TOTAL_W-1:0]     total_q;
  logic                   out_vld_q;
  out_item_t              out_q;

  logic signed [MW-1:0]   op_x, op_y;
  logic [L-1:0]           limb_x, limb_y;
  logic [PW-1:0]          wide_term, wide_base;
  logic [1:0]             limb_sh;
  logic [SW-1:0]          cand, rhs;
  logic [TOTAL_W:0]       sum;
  logic [TOTAL_W-1:0]     total_sat;
  logic                   out_free, emit;
  logic signed [CW-1:0]   crd [9];

  // Unpack p, q, r (p in the top bits), x in the low bits of each vertex.
  always_comb begin
    for (int v = 0; v < 3; v++) begin
      for (int c = 0; c < 3; c++) begin
        crd[3*v+c] = ent_q[(2-v)*VW + c*CW +: CW];
      end
    end
  end

  // Shared multiplier operands.
  always_comb begin
    op_x   = '0;
    op_y   = '0;
    limb_x = cnt_q[1] ? (cnt_q[2] ? mag_q[NW-1:L] : na_q[NW-1:L])
                      : (cnt_q[2] ? mag_q[L-1:0]  : na_q[L-1:0]);
    limb_y = cnt_q[0] ? (cnt_q[2] ? mag_q[NW-1:L] : nb_q[NW-1:L])
                      : (cnt_q[2] ? mag_q[L-1:0]  : nb_q[L-1:0]);
    if (state_q == B_WMUL) begin
      op_x = $signed({1'b0, limb_x});
      op_y = $signed({1'b0, limb_y});
    end else begin
      case (cnt_q)
        4'd0:    begin op_x = MW'(a_q[0]); op_y = MW'(a_q[0]); end
        4'd1:    begin op_x = MW'(a_q[1]); op_y = MW'(a_q[1]); end
        4'd2:    begin op_x = MW'(a_q[2]); op_y = MW'(a_q[2]); end
        4'd3:    begin op_x = MW'(b_q[0]); op_y = MW'(b_q[0]); end
        4'd4:    begin op_x = MW'(b_q[1]); op_y = MW'(b_q[1]); end
        4'd5:    begin op_x = MW'(b_q[2]); op_y = MW'(b_q[2]); end
        4'd6:    begin op_x = MW'(a_q[0]); op_y = MW'(b_q[0]); end
        4'd7:    begin op_x = MW'(a_q[1]); op_y = MW'(b_q[1]); end
        4'd8:    begin op_x = MW'(a_q[2]); op_y = MW'(b_q[2]); end
        default: begin op_x = '0;          op_y = '0;          end
      endcase
    end
  end

  // Place a limb product at its weight.
  always_comb begin
    limb_sh   = {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]};
    wide_base = PW'(prod_q[2*L-1:0]);
    case (limb_sh)
      2'd0:    wide_term = wide_base;
      2'd1:    wide_term = wide_base << L;
      default: wide_term = wide_base << (2 * L);
    endcase
  end

  assign cand = tmp_q + (t_q << (bit_q + 4'd1));
  assign rhs  = SW'(dd_q) << 30;

  assign sum       = {1'b0, total_q} + (TOTAL_W + 1)'(best_q);
  assign total_sat = (sum > (TOTAL_W + 1)'(CAP)) ? CAP : sum[TOTAL_W-1:0];
  assign out_free  = !out_vld_q || !out_stall_i;
  assign emit      = (state_q == B_EMIT) && out_free;
  assign job_pop_o = (state_q == B_IDLE) && job_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= B_IDLE;
      out_vld_q <= 1'b0;
      best_q    <= '0;
      total_q   <= '0;
    end else begin
      if (emit) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        B_IDLE: begin
          if (job_valid_i) begin
            state_q <= job_ctl_i.corner ? B_DIFF : B_EMIT;
          end
        end
        B_DIFF:   state_q <= B_MUL;
        B_MUL:    state_q <= B_ACC;
        B_ACC:    state_q <= (cnt_q == 4'd8) ? B_CHECK : B_MUL;
        B_CHECK: begin
          if (na_q == '0 || nb_q == '0 || dot_q <= 0) begin
            state_q <= B_FIN;
          end else begin
            state_q <= B_WMUL;
          end
        end
        B_WMUL:   state_q <= B_WACC;
        B_WACC:   state_q <= (cnt_q == 4'd7) ? B_SRCH_A : B_WMUL;
        B_SRCH_A: state_q <= B_SRCH_B;
        B_SRCH_B: state_q <= (bit_q == 4'd0) ? B_FIN : B_SRCH_A;
        B_FIN: begin
          if (k_q > best_q) begin
            best_q <= k_q;
          end
          state_q <= ctl_q.last ? B_EMIT : B_IDLE;
        end
        B_EMIT: begin
          if (out_free) begin
            total_q <= ctl_q.grp ? '0 : total_sat;
            best_q  <= '0;
            state_q <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      ent_q <= job_data_i;
      ctl_q <= job_ctl_i;
    end
    if (emit) begin
      out_q <= '{face_score: best_q, group_total: total_sat, group_done: ctl_q.grp};
    end
    case (state_q)
      B_DIFF: begin
        for (int c = 0; c < 3; c++) begin
          a_q[c] <= DW'(crd[c])   - DW'(crd[3+c]);
          b_q[c] <= DW'(crd[3+c]) - DW'(crd[6+c]);
        end
        na_q  <= '0;
        nb_q  <= '0;
        dot_q <= '0;
        cnt_q <= 4'd0;
      end
      B_MUL, B_WMUL: prod_q <= op_x * op_y;
      B_ACC: begin
        if (cnt_q < 4'd3) begin
          na_q <= na_q + NW'(prod_q);
        end else if (cnt_q < 4'd6) begin
          nb_q <= nb_q + NW'(prod_q);
        end else begin
          dot_q <= dot_q + NW'(prod_q);
        end
        cnt_q <= cnt_q + 4'd1;
      end
      B_CHECK: begin
        mag_q <= NW'(dot_q);
        pn_q  <= '0;
        dd_q  <= '0;
        cnt_q <= 4'd0;
        k_q   <= '0;
      end
      B_WACC: begin
        if (cnt_q[2]) begin
          dd_q <= dd_q + wide_term;
        end else begin
          pn_q <= pn_q + wide_term;
        end
        cnt_q <= cnt_q + 4'd1;
        s_q   <= '0;
        t_q   <= '0;
        bit_q <= 4'd15;
      end
      B_SRCH_A: tmp_q <= s_q + (SW'(pn_q) << (5'(bit_q) << 1));
      B_SRCH_B: begin
        if (cand <= rhs) begin
          s_q        <= cand;
          t_q        <= t_q + (SW'(pn_q) << bit_q);
          k_q[bit_q] <= 1'b1;
        end
        bit_q <= bit_q - 4'd1;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

endmodule

// ----- hw/rtl/pfs_checker.sv -----
// ----------------------------------------------------------------------------
// pfs_checker
// Port-level checks on the face skewness core, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pfs_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input pfs_pkg::in_item_t   in_item_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input pfs_pkg::out_item_t  out_item_o
);
  import pfs_pkg::*;

  `PFS_ASSERT_NEXT(a_face_end_pauses, in_valid_i && !in_stall_o && in_item_i.face_end, in_stall_o, "face end item did not pause input")
  `PFS_ASSERT(a_score_range, out_valid_o, out_item_o.face_score <= SCORE_W'(ONE_Q15), "face score above one")
  `PFS_ASSERT(a_total_covers, out_valid_o, out_item_o.group_total >= TOTAL_W'(out_item_o.face_score), "group total below face score")
  `PFS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_item_o), "stalled result changed")

endmodule

bind polygon_face_skewness_core pfs_checker u_pfs_checker (.*);
